### hw/rtl/assert_macros.svh
// Assertion helper macros used by min_max_decimator_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mmd_pkg.sv
// ----------------------------------------------------------------------------
// mmd_pkg
// Constants and types of the min/max display decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package mmd_pkg;

    localparam int DEPTH_DEFAULT      = 1024;
    localparam int MAX_POINTS_DEFAULT = 64;

    localparam logic [1:0] REG_WINDOW_LEFT   = 2'd0;
    localparam logic [1:0] REG_WINDOW_RIGHT  = 2'd1;
    localparam logic [1:0] REG_POINT_BUDGET  = 2'd2;
    localparam logic [1:0] REG_DISPLAY_START = 2'd3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SETUP,
        ST_DIV,
        ST_RD,
        ST_SCAN,
        ST_RDLO,
        ST_RDHI,
        ST_EMIT1,
        ST_EMIT2
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/mmd_ram.sv
// ----------------------------------------------------------------------------
// mmd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/min_max_decimator_core.sv
// ----------------------------------------------------------------------------
// min_max_decimator_core
// Min/max bucket decimation of a time-ordered sample run for display.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries samples: tdata = {value, time, seq}, tlast = final sample.
//   m_axis carries display points: tdata = {value, time}, tuser = overflow,
//   tlast = last point of the run.
//   Configuration registers are written through cfg_we/cfg_addr/cfg_data;
//   the user is to write them only while the block is idle (not enforced).
//   Samples are taken one per cycle. A sample with tlast closes the run:
//   s_axis_tready then drops while the store is walked. The bucket size is
//   found by a restoring divide of n - 1 by the bucket count, half the point
//   budget; each bucket is then read, scanned entry by entry for its minimum
//   and maximum, and emitted as one point, or as two in time order when they
//   differ. A run that fits the budget is emitted sample by sample, one
//   point per stored sample.
//   A stalled m_axis holds the point in the output register and halts the
//   walk. Reset clears the count, overflow flag, registers and control; the
//   stores need no clearing, since only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module min_max_decimator_core #(
    parameter int DEPTH      = mmd_pkg::DEPTH_DEFAULT,
    parameter int MAX_POINTS = mmd_pkg::MAX_POINTS_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // sample_seq[63:0], sample_time[127:64], sample_value[159:128]
    input  wire logic [159:0] s_axis_tdata,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // point_time[63:0], point_value[95:64]
    output logic      [95:0]  m_axis_tdata,
    output logic              m_axis_tlast,
    // store_overflow[0]
    output logic              m_axis_tuser,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [63:0]  cfg_data
);

    import mmd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int BW = $clog2(MAX_POINTS + 1);

    state_t state_reg, state_next;

    logic signed [63:0] wleft_reg, wright_reg;
    logic        [63:0] dstart_reg;
    logic        [6:0]  budget_reg;
    logic        [CW-1:0] count_reg;
    logic               ovf_reg;

    logic [CW-1:0] n_reg;          // kept samples in run
    logic [CW-1:0] bsize_reg;      // bucket size / quotient
    logic [CW-1:0] rem_reg;        // divider remainder
    logic [BW-1:0] div_reg;        // divisor (bucket count)
    logic [$clog2(CW+1)-1:0] dcnt_reg;
    logic          passall_reg;
    logic [CW-1:0] idx_reg, end_reg, rd_reg;
    logic [CW-1:0] lo_reg, hi_reg;
    logic signed [31:0] loval_reg, hival_reg;
    logic signed [63:0] lotime_reg;
    logic          first_reg;

    logic [AW-1:0]      raddr;
    logic signed [63:0] t_rdata;
    logic signed [31:0] v_rdata;
    logic               wr_en;

    logic [63:0]        in_seq;
    logic signed [63:0] in_time;
    logic signed [31:0] in_value;
    logic               keep;
    logic               in_fire, out_free;
    logic [6:0]         bud_eff;

    assign in_seq   = s_axis_tdata[63:0];
    assign in_time  = s_axis_tdata[127:64];
    assign in_value = s_axis_tdata[159:128];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign keep     = (in_seq >= dstart_reg) && (wleft_reg <= in_time)
                      && (in_time <= wright_reg);
    assign wr_en    = in_fire && keep && (count_reg < CW'(DEPTH));

    always_comb
    begin
        bud_eff = budget_reg;
        if (budget_reg < 7'd2)
        begin
            bud_eff = 7'd2;
        end
        else if (budget_reg > 7'(MAX_POINTS))
        begin
            bud_eff = 7'(MAX_POINTS);
        end
    end

    mmd_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_time_ram (
        .clk(clk), .we(wr_en), .waddr(count_reg[AW-1:0]), .wdata(in_time),
        .raddr(raddr), .rdata(t_rdata)
    );

    mmd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_value_ram (
        .clk(clk), .we(wr_en), .waddr(count_reg[AW-1:0]), .wdata(in_value),
        .raddr(raddr), .rdata(v_rdata)
    );

    always_comb
    begin
        raddr = idx_reg[AW-1:0];
        case (state_reg)
            ST_RDLO: raddr = lo_reg[AW-1:0];
            ST_RDHI, ST_EMIT1: raddr = hi_reg[AW-1:0];
            default: raddr = idx_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_LOAD);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (in_fire && s_axis_tlast)
                begin
                    state_next = ST_SETUP;
                end
            ST_SETUP:
                if (n_reg == '0)
                begin
                    state_next = ST_LOAD;
                end
                else if (n_reg <= CW'(bud_eff))
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            ST_DIV:
                if (dcnt_reg == '0)
                begin
                    state_next = ST_RD;
                end
            ST_RD:
                state_next = passall_reg ? ST_EMIT1 : ST_SCAN;
            ST_SCAN:
                if (rd_reg + 1'b1 >= end_reg)
                begin
                    state_next = ST_RDLO;
                end
            ST_RDLO:
                state_next = ST_RDHI;
            ST_RDHI:
                state_next = ST_EMIT1;
            ST_EMIT1:
                if (out_free)
                begin
                    if (passall_reg)
                    begin
                        state_next = (idx_reg >= n_reg) ? ST_LOAD : ST_RD;
                    end
                    else if (lo_reg != hi_reg)
                    begin
                        state_next = ST_EMIT2;
                    end
                    else
                    begin
                        state_next = (end_reg >= n_reg) ? ST_LOAD : ST_RD;
                    end
                end
            ST_EMIT2:
                if (out_free)
                begin
                    state_next = (end_reg >= n_reg) ? ST_LOAD : ST_RD;
                end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            wleft_reg  <= '0;
            wright_reg <= 64'h7FFF_FFFF_FFFF_FFFF;
            budget_reg <= 7'd64;
            dstart_reg <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_WINDOW_LEFT:   wleft_reg  <= cfg_data;
                    REG_WINDOW_RIGHT:  wright_reg <= cfg_data;
                    REG_POINT_BUDGET:  budget_reg <= cfg_data[6:0];
                    REG_DISPLAY_START: dstart_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (wr_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (in_fire && keep)
            begin
                ovf_reg <= 1'b1;
            end
            if (state_reg == ST_SETUP)
            begin
                count_reg <= '0;
            end
            if ((state_reg == ST_EMIT1 || state_reg == ST_EMIT2) && out_free)
            begin
                m_axis_tvalid <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                m_axis_tvalid <= 1'b0;
            end
            if (state_reg == ST_SETUP)
            begin
                if (n_reg == '0)
                begin
                    ovf_reg <= 1'b0;
                end
            end
            else if (state_next == ST_LOAD && state_reg != ST_LOAD)
            begin
                ovf_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOAD:
                if (in_fire && s_axis_tlast)
                begin
                    n_reg <= wr_en ? count_reg + 1'b1 : count_reg;
                end
            ST_SETUP:
            begin
                passall_reg <= (n_reg <= CW'(bud_eff));
                div_reg     <= BW'(bud_eff >> 1);
                bsize_reg   <= n_reg - 1'b1;
                rem_reg     <= '0;
                dcnt_reg    <= ($clog2(CW+1))'(CW);
                idx_reg     <= '0;
                end_reg     <= '0;
            end
            ST_DIV:
            begin
                // restoring divide of (n-1) by bucket count, one bit a cycle
                if (dcnt_reg != '0)
                begin
                    if ({rem_reg[CW-2:0], bsize_reg[CW-1]} >= CW'(div_reg))
                    begin
                        rem_reg <= {rem_reg[CW-2:0], bsize_reg[CW-1]} - CW'(div_reg);
                        bsize_reg <= {bsize_reg[CW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[CW-2:0], bsize_reg[CW-1]};
                        bsize_reg <= {bsize_reg[CW-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
                else
                begin
                    bsize_reg <= bsize_reg + 1'b1;
                end
            end
            ST_RD:
            begin
                rd_reg  <= idx_reg;
                lo_reg  <= idx_reg;
                hi_reg  <= idx_reg;
                first_reg <= 1'b1;
                if (!passall_reg)
                begin
                    end_reg <= (n_reg - idx_reg > bsize_reg) ? idx_reg + bsize_reg
                                                             : n_reg;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            ST_SCAN:
            begin
                first_reg <= 1'b0;
                if (first_reg || v_rdata < loval_reg)
                begin
                    loval_reg <= v_rdata;
                    lo_reg    <= rd_reg;
                end
                if (first_reg || hival_reg < v_rdata)
                begin
                    hival_reg <= v_rdata;
                    hi_reg    <= rd_reg;
                end
                rd_reg  <= rd_reg + 1'b1;
                if (rd_reg + 1'b1 < end_reg)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_RDHI:
            begin
                lotime_reg <= t_rdata;
                loval_reg  <= v_rdata;
            end
            ST_EMIT1:
                if (out_free)
                begin
                    if (passall_reg)
                    begin
                        m_axis_tdata <= {v_rdata, t_rdata};
                        m_axis_tlast <= (idx_reg >= n_reg);
                    end
                    else if (lo_reg == hi_reg)
                    begin
                        m_axis_tdata <= {loval_reg, lotime_reg};
                        m_axis_tlast <= (end_reg >= n_reg);
                    end
                    else if (lotime_reg <= t_rdata)
                    begin
                        m_axis_tdata <= {loval_reg, lotime_reg};
                        m_axis_tlast <= 1'b0;
                        hival_reg    <= v_rdata;
                        lotime_reg   <= t_rdata;
                    end
                    else
                    begin
                        m_axis_tdata <= {v_rdata, t_rdata};
                        m_axis_tlast <= 1'b0;
                        hival_reg    <= loval_reg;
                    end
                    m_axis_tuser <= ovf_reg;
                end
            ST_EMIT2:
                if (out_free)
                begin
                    m_axis_tdata <= {hival_reg, lotime_reg};
                    m_axis_tlast <= (end_reg >= n_reg);
                    m_axis_tuser <= ovf_reg;
                end
            default: ;
        endcase
    end

    `ASSERT_IMPLIES(a_no_load_while_busy, clk, rst_n,
        state_reg != ST_LOAD, !s_axis_tready, "input accepted while draining")
    `ASSERT_IMPLIES(a_count_bound, clk, rst_n,
        1'b1, count_reg <= CW'(DEPTH), "kept count above store depth")
    `ASSERT_NEXT(a_setup_clears, clk, rst_n,
        state_reg == ST_SETUP, count_reg == '0, "count not cleared at run end")

endmodule

`default_nettype wire
